// ----- src/rime_pkg.sv -----
// ----------------------------------------------------------------------------
// rime_pkg: shared types and constants of the raw image mirror engine
// Opcodes, queue commands, status codes, phases and frame store sizing.
// ----------------------------------------------------------------------------
`default_nettype none

package rime_pkg;

  localparam int MAX_FRAME_BYTES = 262144;
  localparam int ADDR_W          = $clog2(MAX_FRAME_BYTES);

  localparam int QUEUE_DEPTH = 4;
  localparam int Q_PTR_W     = $clog2(QUEUE_DEPTH);
  localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_MIRROR_LR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIRROR_TB = 2'd1;

  localparam logic [1:0] OP_PUSH = 2'd0;
  localparam logic [1:0] OP_EOF  = 2'd1;
  localparam logic [1:0] OP_PULL = 2'd2;

  localparam logic [1:0] CMD_PUSH = 2'd0;
  localparam logic [1:0] CMD_EOF  = 2'd1;
  localparam logic [1:0] CMD_PULL = 2'd2;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_SHORT    = 3'd1;
  localparam logic [2:0] ST_ENDIAN   = 3'd2;
  localparam logic [2:0] ST_ZERO     = 3'd3;
  localparam logic [2:0] ST_DEPTH    = 3'd4;
  localparam logic [2:0] ST_CHANNELS = 3'd5;
  localparam logic [2:0] ST_LENGTH   = 3'd6;
  localparam logic [2:0] ST_TOO_BIG  = 3'd7;

  localparam logic RK_STATUS = 1'b0;
  localparam logic RK_DATA   = 1'b1;

  localparam logic [1:0] PH_LOAD   = 2'd0;
  localparam logic [1:0] PH_OUT    = 2'd1;
  localparam logic [1:0] PH_REJECT = 2'd2;
  localparam logic [1:0] PH_DONE   = 2'd3;

  localparam logic [15:0] MAGIC_II = 16'h4949;
  localparam logic [15:0] MAGIC_MM = 16'h4d4d;

  localparam logic [13:0] DEPTH_8BIT  = 14'd3;
  localparam logic [13:0] DEPTH_16BIT = 14'd4;

  localparam logic [1:0] CHAN_ONE   = 2'd0;
  localparam logic [1:0] CHAN_THREE = 2'd2;
  localparam logic [1:0] CHAN_FOUR  = 2'd3;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
  } cmd_t;

endpackage

`default_nettype wire

// ----- src/rime_if.sv -----
// ----------------------------------------------------------------------------
// rime_if: channel interfaces of the raw image mirror engine
// Input, result and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

interface rime_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [7:0] file_byte;
  modport source (output valid, opcode, file_byte, input ready);
  modport sink   (input valid, opcode, file_byte, output ready);
endinterface

interface rime_out_if;
  logic       valid;
  logic       ready;
  logic       result_kind;
  logic [2:0] status_code;
  logic [7:0] out_byte;
  logic       last_byte;
  modport source (output valid, result_kind, status_code, out_byte, last_byte,
                  input ready);
  modport sink   (input valid, result_kind, status_code, out_byte, last_byte,
                  output ready);
endinterface

interface rime_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [0:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- src/rime_front.sv -----
// ----------------------------------------------------------------------------
// rime_front: input decode stage
// Accepts input transactions, turns opcodes into queue commands, drops
// reserved opcodes.
// ----------------------------------------------------------------------------
`default_nettype none

module rime_front import rime_pkg::*; (
  rime_in_if.sink  in_ch,
  output logic     wr_valid,
  output cmd_t     wr_cmd,
  input  logic     wr_ready
);

  logic known;

  always_comb begin
    known       = 1'b1;
    wr_cmd.data = in_ch.file_byte;
    case (in_ch.opcode)
      OP_PUSH: wr_cmd.kind = CMD_PUSH;
      OP_EOF:  wr_cmd.kind = CMD_EOF;
      OP_PULL: wr_cmd.kind = CMD_PULL;
      default: begin
        wr_cmd.kind = CMD_PUSH;
        known       = 1'b0;
      end
    endcase
  end

  assign in_ch.ready = wr_ready;
  assign wr_valid    = in_ch.valid && known;

endmodule

`default_nettype wire

// ----- src/rime_queue.sv -----
// ----------------------------------------------------------------------------
// rime_queue: command queue between front and back
// Small FIFO of decoded commands so each side stalls on its own.
// ----------------------------------------------------------------------------
`default_nettype none

module rime_queue import rime_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic wr_valid,
  input  cmd_t wr_cmd,
  output logic wr_ready,
  output logic rd_valid,
  output cmd_t rd_cmd,
  input  logic rd_pop
);

  cmd_t               slots_r [QUEUE_DEPTH];
  logic [Q_PTR_W-1:0] wptr_r;
  logic [Q_PTR_W-1:0] rptr_r;
  logic [Q_CNT_W-1:0] cnt_r;
  logic               do_wr;
  logic               do_rd;

  assign wr_ready = (cnt_r != Q_CNT_W'(QUEUE_DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_cmd   = slots_r[rptr_r];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_pop && rd_valid;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots_r[wptr_r] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (do_wr) begin
        wptr_r <= wptr_r + Q_PTR_W'(1);
      end
      if (do_rd) begin
        rptr_r <= rptr_r + Q_PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        cnt_r <= cnt_r + Q_CNT_W'(1);
      end else if (do_rd && !do_wr) begin
        cnt_r <= cnt_r - Q_CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ----- src/rime_back.sv -----
// ----------------------------------------------------------------------------
// rime_back: execution stage
// Loads header and frame store, checks the file at end of file and walks
// the mirrored output, header register first, then frame store, one pull at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module rime_back import rime_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         q_valid,
  input  cmd_t         q_cmd,
  output logic         q_pop,
  rime_cfg_if.sink     cfg,
  rime_out_if.source   out_ch
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_CHK  = 3'd2;
  localparam logic [2:0] S_ADR  = 3'd3;
  localparam logic [2:0] S_RD   = 3'd4;
  localparam logic [2:0] S_DAT  = 3'd5;
  localparam logic [2:0] S_EMIT = 3'd6;

  logic [2:0]        state_r;
  logic [1:0]        phase_r;
  logic [63:0]       hdr_r;
  logic [31:0]       cnt_r;
  logic [15:0]       row_r;
  logic [15:0]       col_r;
  logic [3:0]        bip_r;
  logic [3:0]        hidx_r;
  logic              lr_r;
  logic              tb_r;

  logic [ADDR_W-1:0] prod_r;
  logic [ADDR_W-1:0] addr_r;
  logic [15:0]       sc_r;
  logic [3:0]        pbip_r;
  logic [31:0]       wh_r;
  logic [35:0]       need_r;
  logic [7:0]        rd_data_r;

  logic              res_kind_r;
  logic [2:0]        res_status_r;
  logic [7:0]        res_byte_r;
  logic              res_last_r;

  logic              ov_r;
  logic              okind_r;
  logic [2:0]        ostatus_r;
  logic [7:0]        obyte_r;
  logic              olast_r;

  logic [7:0]        mem [MAX_FRAME_BYTES];

  logic [15:0]       endian;
  logic              swap;
  logic [15:0]       img_w;
  logic [15:0]       img_h;
  logic [15:0]       img_fmt;
  logic [13:0]       dcode;
  logic [1:0]        ccode;
  logic [3:0]        ch_n;
  logic [3:0]        pb;
  logic [15:0]       sr;
  logic [15:0]       sc;
  logic [31:0]       prod_full;
  logic [31:0]       wh_full;
  logic [35:0]       need_nxt;
  logic [ADDR_W-1:0] base;
  logic [ADDR_W-1:0] addr_nxt;
  logic [2:0]        status;
  logic [31:0]       pix_idx;
  logic              in_store;
  logic              mem_we;
  logic              bip_end;
  logic              col_end;
  logic              row_end;
  logic              emit_go;

  assign endian  = {hdr_r[15:8], hdr_r[7:0]};
  assign swap    = (endian == MAGIC_MM);
  assign img_w   = swap ? {hdr_r[23:16], hdr_r[31:24]} : {hdr_r[31:24], hdr_r[23:16]};
  assign img_h   = swap ? {hdr_r[39:32], hdr_r[47:40]} : {hdr_r[47:40], hdr_r[39:32]};
  assign img_fmt = swap ? {hdr_r[55:48], hdr_r[63:56]} : {hdr_r[63:56], hdr_r[55:48]};
  assign dcode   = img_fmt[15:2];
  assign ccode   = img_fmt[1:0];

  always_comb begin
    case (ccode)
      CHAN_THREE: ch_n = 4'd3;
      CHAN_FOUR:  ch_n = 4'd4;
      default:    ch_n = 4'd1;
    endcase
    pb = (dcode == DEPTH_16BIT) ? {ch_n[2:0], 1'b0} : ch_n;
  end

  assign sr        = tb_r ? (img_h - 16'd1 - row_r) : row_r;
  assign sc        = lr_r ? (img_w - 16'd1 - col_r) : col_r;
  assign prod_full = 32'(sr) * 32'(img_w);
  assign wh_full   = 32'(img_w) * 32'(img_h);
  assign need_nxt  = {4'b0, wh_r} * 36'(pb);
  assign base      = prod_r + ADDR_W'(sc_r);
  assign addr_nxt  = base * ADDR_W'(pb) + ADDR_W'(pbip_r);

  assign bip_end = ((bip_r + 4'd1) == pb);
  assign col_end = ((col_r + 16'd1) == img_w);
  assign row_end = ((row_r + 16'd1) == img_h);

  always_comb begin
    if (cnt_r < 32'd8) begin
      status = ST_SHORT;
    end else if (endian != MAGIC_II && endian != MAGIC_MM) begin
      status = ST_ENDIAN;
    end else if (img_w == 16'd0 || img_h == 16'd0) begin
      status = ST_ZERO;
    end else if (dcode != DEPTH_8BIT && dcode != DEPTH_16BIT) begin
      status = ST_DEPTH;
    end else if (ccode != CHAN_ONE && ccode != CHAN_THREE && ccode != CHAN_FOUR) begin
      status = ST_CHANNELS;
    end else if ({4'b0, cnt_r} != need_r + 36'd8) begin
      status = ST_LENGTH;
    end else if (need_r > 36'(MAX_FRAME_BYTES)) begin
      status = ST_TOO_BIG;
    end else begin
      status = ST_OK;
    end
  end

  assign q_pop    = (state_r == S_IDLE) && q_valid;
  assign pix_idx  = cnt_r - 32'd8;
  assign in_store = (cnt_r >= 32'd8) && (pix_idx < 32'(MAX_FRAME_BYTES));
  assign mem_we   = q_pop && (q_cmd.kind == CMD_PUSH) && (phase_r == PH_LOAD) && in_store;
  assign emit_go  = (state_r == S_EMIT) && (!ov_r || out_ch.ready);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[pix_idx[ADDR_W-1:0]] <= q_cmd.data;
    end
    rd_data_r <= mem[addr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      phase_r <= PH_LOAD;
      hdr_r   <= '0;
      cnt_r   <= '0;
      row_r   <= '0;
      col_r   <= '0;
      bip_r   <= '0;
      hidx_r  <= '0;
      lr_r    <= 1'b0;
      tb_r    <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      if (cfg.valid) begin
        case (cfg.index)
          CFG_MIRROR_LR: lr_r <= cfg.data[0];
          CFG_MIRROR_TB: tb_r <= cfg.data[0];
          default: ;
        endcase
      end
      if (emit_go) begin
        ov_r <= 1'b1;
      end else if (ov_r && out_ch.ready) begin
        ov_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            case (q_cmd.kind)
              CMD_PUSH: begin
                if (phase_r == PH_LOAD) begin
                  if (cnt_r < 32'd8) begin
                    hdr_r[{cnt_r[2:0], 3'b000} +: 8] <= q_cmd.data;
                  end
                  if (cnt_r != '1) begin
                    cnt_r <= cnt_r + 32'd1;
                  end
                end
              end
              CMD_EOF: begin
                wh_r    <= wh_full;
                state_r <= S_MUL;
              end
              CMD_PULL: begin
                if (phase_r == PH_OUT) begin
                  if (!hidx_r[3]) begin
                    res_kind_r   <= RK_DATA;
                    res_status_r <= ST_OK;
                    res_byte_r   <= hdr_r[{hidx_r[2:0], 3'b000} +: 8];
                    res_last_r   <= 1'b0;
                    hidx_r       <= hidx_r + 4'd1;
                    state_r      <= S_EMIT;
                  end else begin
                    prod_r     <= prod_full[ADDR_W-1:0];
                    sc_r       <= sc;
                    pbip_r     <= bip_r;
                    res_last_r <= bip_end && col_end && row_end;
                    if (bip_end) begin
                      bip_r <= '0;
                      if (col_end) begin
                        col_r <= '0;
                        row_r <= row_r + 16'd1;
                        if (row_end) begin
                          phase_r <= PH_DONE;
                        end
                      end else begin
                        col_r <= col_r + 16'd1;
                      end
                    end else begin
                      bip_r <= bip_r + 4'd1;
                    end
                    state_r <= S_ADR;
                  end
                end
              end
              default: ;
            endcase
          end
        end
        S_MUL: begin
          need_r  <= need_nxt;
          state_r <= S_CHK;
        end
        S_CHK: begin
          res_kind_r   <= RK_STATUS;
          res_status_r <= status;
          res_byte_r   <= 8'd0;
          res_last_r   <= 1'b0;
          if (phase_r == PH_LOAD) begin
            phase_r <= (status == ST_OK) ? PH_OUT : PH_REJECT;
          end
          state_r <= S_EMIT;
        end
        S_ADR: begin
          addr_r  <= addr_nxt;
          state_r <= S_RD;
        end
        S_RD: begin
          state_r <= S_DAT;
        end
        S_DAT: begin
          res_kind_r   <= RK_DATA;
          res_status_r <= ST_OK;
          res_byte_r   <= rd_data_r;
          state_r      <= S_EMIT;
        end
        S_EMIT: begin
          if (emit_go) begin
            okind_r   <= res_kind_r;
            ostatus_r <= res_status_r;
            obyte_r   <= res_byte_r;
            olast_r   <= res_last_r;
            state_r   <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign cfg.ready          = 1'b1;
  assign out_ch.valid       = ov_r;
  assign out_ch.result_kind = okind_r;
  assign out_ch.status_code = ostatus_r;
  assign out_ch.out_byte    = obyte_r;
  assign out_ch.last_byte   = olast_r;

endmodule

`default_nettype wire

// ----- src/raw_image_mirror_engine.sv -----
// ----------------------------------------------------------------------------
// raw_image_mirror_engine: raw image flip engine, top level
// Stream a raw image file in byte by byte (opcode push), close it with end
// of file, then pull the mirrored file out one byte per pull transaction.
//
// Channels: in_ch carries opcode and file_byte; out_ch carries result_kind,
// status_code, out_byte and last_byte; cfg_ch writes mirror_left_right
// (index 0) and mirror_top_bottom (index 1) and is always ready.
// A decode front pushes commands into a four-entry queue; the back unit
// executes one command at a time.
// Back unit steps per transaction: a push, or a pull outside the output phase,
// is done in the idle state; a header pull goes straight to the output register
// load; a pixel pull registers the row*width multiply, the address scale and
// the frame store read in turn; end of file registers two chained multiplies
// for the length check before the status goes to the output register.
// Reset clears the header, byte count, output position and mirror bits and
// returns to the loading phase; the frame store is not cleared.
// A stalled receiver holds the result in the output register; the back unit
// finishes one more result, waits with it, and the queue then backs up into in_ch.
// ----------------------------------------------------------------------------
`default_nettype none

module raw_image_mirror_engine import rime_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  rime_in_if.sink    in_ch,
  rime_out_if.source out_ch,
  rime_cfg_if.sink   cfg_ch
);

  logic wr_valid;
  cmd_t wr_cmd;
  logic wr_ready;
  logic rd_valid;
  cmd_t rd_cmd;
  logic rd_pop;

  rime_front u_front (
    .in_ch    (in_ch),
    .wr_valid (wr_valid),
    .wr_cmd   (wr_cmd),
    .wr_ready (wr_ready)
  );

  rime_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (wr_valid),
    .wr_cmd   (wr_cmd),
    .wr_ready (wr_ready),
    .rd_valid (rd_valid),
    .rd_cmd   (rd_cmd),
    .rd_pop   (rd_pop)
  );

  rime_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (rd_valid),
    .q_cmd   (rd_cmd),
    .q_pop   (rd_pop),
    .cfg     (cfg_ch),
    .out_ch  (out_ch)
  );

endmodule

`default_nettype wire

// ----- src/rime_checker.sv -----
// ----------------------------------------------------------------------------
// rime_checker: port-level checks of the raw image mirror engine
// Watches the result channel and is bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rime_checker import rime_pkg::*; (
  input wire       clk,
  input wire       rst_n,
  input wire       out_valid,
  input wire       out_ready,
  input wire       result_kind,
  input wire [2:0] status_code,
  input wire [7:0] out_byte,
  input wire       last_byte
);

  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(result_kind) &&
      $stable(status_code) && $stable(out_byte) && $stable(last_byte))
    else $error("stalled result changed");

  a_data_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && result_kind == RK_DATA |-> status_code == ST_OK)
    else $error("data transaction with nonzero status");

  a_status_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && result_kind == RK_STATUS |-> out_byte == 8'd0 && !last_byte)
    else $error("status transaction with data fields set");

  a_last_is_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && last_byte && out_ready |=> !(out_valid && result_kind == RK_DATA))
    else $error("data transaction after last byte");

endmodule

bind raw_image_mirror_engine rime_checker u_rime_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .result_kind (out_ch.result_kind),
  .status_code (out_ch.status_code),
  .out_byte    (out_ch.out_byte),
  .last_byte   (out_ch.last_byte)
);

`default_nettype wire

// ----- test/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: testbench of the raw image mirror engine
// Streams one random-format raw image with noise commands, then pulls the
// mirrored file back while the mirror bits change between quiet points.
// A scoreboard predicts every status and data transaction from its own copy
// of the header, pixel store and output position; both channels stall at
// random, and one long receiver hold-off backs the command queue up.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  import rime_pkg::*;

  localparam int LIMIT_CYCLES = 500000;
  localparam int DRAIN_CYCLES = 48;
  localparam int PIXEL_TARGET = 330;

  typedef struct packed {
    logic       kind;
    logic [2:0] status;
    logic [7:0] data;
    logic       last;
  } mirror_result_t;

  class mirror_scoreboard;
    mirror_result_t pending[$];
    logic [7:0]     header_bytes[8];
    logic [31:0]    byte_count;
    logic [7:0]     pixel_mem[];
    logic [15:0]    row;
    logic [15:0]    col;
    logic [3:0]     sub;
    logic [3:0]     hdr_idx;
    logic [1:0]     phase;
    logic           flip_lr;
    logic           flip_tb;
    int             mismatches;

    function new();
      pixel_mem = new[MAX_FRAME_BYTES];
      foreach (header_bytes[i]) header_bytes[i] = 8'h00;
      byte_count = '0;
      row = '0;
      col = '0;
      sub = '0;
      hdr_idx = '0;
      phase = PH_LOAD;
      flip_lr = 1'b0;
      flip_tb = 1'b0;
      mismatches = 0;
    endfunction

    function int pending_count();
      return pending.size();
    endfunction

    function void set_mirror(logic [1:0] idx, logic val);
      if (idx == CFG_MIRROR_LR) flip_lr = val;
      else if (idx == CFG_MIRROR_TB) flip_tb = val;
    endfunction

    function logic [15:0] hdr_word(int i, bit swap);
      logic [7:0] lo;
      logic [7:0] hi;
      lo = header_bytes[2*i];
      hi = header_bytes[2*i+1];
      return swap ? {lo, hi} : {hi, lo};
    endfunction

    function bit big_endian();
      return hdr_word(0, 1'b0) == MAGIC_MM;
    endfunction

    function int unsigned img_width();
      return hdr_word(1, big_endian());
    endfunction

    function int unsigned img_height();
      return hdr_word(2, big_endian());
    endfunction

    function logic [15:0] img_format();
      return hdr_word(3, big_endian());
    endfunction

    function int unsigned bytes_per_pixel();
      logic [15:0] f;
      int unsigned ch;
      f = img_format();
      ch = (f[1:0] == CHAN_ONE) ? 1 : ((f[1:0] == CHAN_THREE) ? 3 : 4);
      return ch * ((f[15:2] == DEPTH_16BIT) ? 2 : 1);
    endfunction

    function logic [2:0] file_status();
      logic [15:0] code;
      logic [15:0] f;
      longint unsigned need;
      if (byte_count < 8) return ST_SHORT;
      code = hdr_word(0, 1'b0);
      if (code != MAGIC_II && code != MAGIC_MM) return ST_ENDIAN;
      if (img_width() == 0 || img_height() == 0) return ST_ZERO;
      f = img_format();
      if (f[15:2] != DEPTH_8BIT && f[15:2] != DEPTH_16BIT) return ST_DEPTH;
      if (f[1:0] != CHAN_ONE && f[1:0] != CHAN_THREE && f[1:0] != CHAN_FOUR)
        return ST_CHANNELS;
      need = longint'(img_width()) * img_height() * bytes_per_pixel();
      if (longint'(byte_count) != need + 8) return ST_LENGTH;
      if (need > MAX_FRAME_BYTES) return ST_TOO_BIG;
      return ST_OK;
    endfunction

    function void accept_command(logic [1:0] op, logic [7:0] b);
      mirror_result_t r;
      int unsigned w;
      int unsigned h;
      int unsigned pb;
      int unsigned src_r;
      int unsigned src_c;
      longint unsigned addr;
      r = '0;
      if (op == OP_PUSH) begin
        if (phase != PH_LOAD) return;
        if (byte_count < 8) header_bytes[byte_count] = b;
        else if (byte_count - 8 < MAX_FRAME_BYTES) pixel_mem[byte_count-8] = b;
        if (byte_count != '1) byte_count++;
      end else if (op == OP_EOF) begin
        r.kind = RK_STATUS;
        r.status = file_status();
        if (phase == PH_LOAD) phase = (r.status == ST_OK) ? PH_OUT : PH_REJECT;
        pending.push_back(r);
      end else if (op == OP_PULL && phase == PH_OUT) begin
        r.kind = RK_DATA;
        r.status = ST_OK;
        if (hdr_idx < 8) begin
          r.data = header_bytes[hdr_idx];
          hdr_idx++;
        end else begin
          w = img_width();
          h = img_height();
          pb = bytes_per_pixel();
          src_r = flip_tb ? h - 1 - row : row;
          src_c = flip_lr ? w - 1 - col : col;
          addr = (longint'(src_r) * w + src_c) * pb + sub;
          r.data = (addr < MAX_FRAME_BYTES) ? pixel_mem[addr] : 8'h00;
          sub++;
          if (sub >= pb) begin
            sub = '0;
            col++;
            if (col >= w) begin
              col = '0;
              row++;
              if (row >= h) begin
                r.last = 1'b1;
                phase = PH_DONE;
              end
            end
          end
        end
        pending.push_back(r);
      end
    endfunction

    function void flag(string what, logic [7:0] want, logic [7:0] got);
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch on %s: expected %0h, got %0h", what, want, got);
    endfunction

    function void check_output(mirror_result_t got);
      mirror_result_t want;
      if (pending.size() == 0) begin
        flag("unexpected transaction, out_byte", 8'h00, got.data);
        return;
      end
      want = pending.pop_front();
      if (got.kind !== want.kind) flag("result_kind", want.kind, got.kind);
      if (got.status !== want.status) flag("status_code", want.status, got.status);
      if (got.data !== want.data) flag("out_byte", want.data, got.data);
      if (got.last !== want.last) flag("last_byte", want.last, got.last);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  bit   hold_req;
  int   in_calm;
  int   out_calm;
  int   burst_left;
  int   cycle_count;
  mirror_scoreboard sb;

  rime_in_if  in_ch();
  rime_out_if out_ch();
  rime_cfg_if cfg_ch();

  raw_image_mirror_engine dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic int pick_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      calm = $urandom_range(20, 60);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic idle_in(int n);
    if (n > 0) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task automatic send_item(logic [1:0] op, logic [7:0] b);
    @(negedge clk);
    in_ch.valid <= 1'b1;
    in_ch.opcode <= op;
    in_ch.file_byte <= b;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    sb.accept_command(op, b);
  endtask

  task automatic offer(logic [1:0] op, logic [7:0] b);
    if (burst_left > 0) burst_left--;
    else idle_in(pick_gap(in_calm));
    send_item(op, b);
  endtask

  task automatic settle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (sb.pending_count() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_mirror(logic [1:0] idx, logic val);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    sb.set_mirror(idx, val);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic reconfigure(logic lr, logic tb);
    settle();
    write_mirror(CFG_MIRROR_LR, lr);
    write_mirror(CFG_MIRROR_TB, tb);
  endtask

  // receiver: random stalls plus one long hold-off on request
  initial begin
    mirror_result_t got;
    int stall;
    stall = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(150, 250)) @(negedge clk);
        hold_req = 1'b0;
      end
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        stall--;
      end else begin
        out_ch.ready <= 1'b1;
      end
      @(posedge clk);
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        got.kind = out_ch.result_kind;
        got.status = out_ch.status_code;
        got.data = out_ch.out_byte;
        got.last = out_ch.last_byte;
        sb.check_output(got);
        stall = pick_gap(out_calm);
      end
    end
  end

  initial begin
    logic [7:0]  hdr[8];
    logic [13:0] depth;
    logic [1:0]  chan;
    logic [15:0] fmt;
    logic [15:0] width;
    logic [15:0] height;
    bit          big;
    int          sel;
    int          pb;
    int          npix;
    int          total_out;
    int          q;
    int          r;
    sb = new();
    hold_req = 1'b0;
    in_calm = 0;
    out_calm = 0;
    burst_left = 0;
    cycle_count = 0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.opcode = OP_PUSH;
    in_ch.file_byte = 8'h00;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_MIRROR_LR;
    cfg_ch.data = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    write_mirror(CFG_MIRROR_LR, 1'b0);
    write_mirror(CFG_MIRROR_TB, 1'b0);

    big = 1'($urandom_range(0, 1));
    depth = $urandom_range(0, 1) ? DEPTH_16BIT : DEPTH_8BIT;
    sel = $urandom_range(0, 2);
    chan = (sel == 0) ? CHAN_ONE : ((sel == 1) ? CHAN_THREE : CHAN_FOUR);
    pb = ((sel == 0) ? 1 : ((sel == 1) ? 3 : 4)) * ((depth == DEPTH_16BIT) ? 2 : 1);
    width = 16'($urandom_range(1, 12));
    height = 16'(PIXEL_TARGET / (int'(width) * pb));
    if (height == 16'd0) height = 16'd1;
    npix = int'(width) * int'(height) * pb;
    fmt = {depth, chan};
    hdr[0] = big ? MAGIC_MM[7:0] : MAGIC_II[7:0];
    hdr[1] = big ? MAGIC_MM[15:8] : MAGIC_II[15:8];
    {hdr[2], hdr[3]} = big ? width : {width[7:0], width[15:8]};
    {hdr[4], hdr[5]} = big ? height : {height[7:0], height[15:8]};
    {hdr[6], hdr[7]} = big ? fmt : {fmt[7:0], fmt[15:8]};

    // load the file; pulls while loading produce nothing
    offer(OP_PULL, rand_byte());
    offer(OP_PULL, rand_byte());
    for (int i = 0; i < 8; i++) begin
      offer(OP_PUSH, hdr[i]);
      if (i == 3) offer(OP_PULL, 8'hFF);
    end
    for (int j = 0; j < npix; j++) begin
      if ($urandom_range(0, 99) < 8) offer(OP_PULL, rand_byte());
      if (j == 0) offer(OP_PUSH, 8'h00);
      else if (j == 1) offer(OP_PUSH, 8'hFF);
      else offer(OP_PUSH, rand_byte());
    end
    offer(OP_EOF, rand_byte());
    offer(OP_EOF, rand_byte());
    offer(OP_PUSH, rand_byte());

    // read back the mirrored file
    total_out = 8 + npix;
    q = npix / 4;
    for (int k = 0; k < total_out; k++) begin
      if (k == 8) reconfigure(1'b1, 1'b0);
      if (k == 8 + q) reconfigure(1'b1, 1'b1);
      if (k == 8 + 2 * q) reconfigure(1'b0, 1'b1);
      if (k == 8 + 3 * q) reconfigure(1'b0, 1'b0);
      if (k == 8 + 2 * q + q / 2) begin
        hold_req = 1'b1;
        burst_left = 40;
      end
      r = $urandom_range(0, 99);
      if (r < 5) offer(OP_EOF, rand_byte());
      else if (r < 10) offer(OP_PUSH, rand_byte());
      offer(OP_PULL, rand_byte());
    end
    offer(OP_PULL, rand_byte());
    offer(OP_PULL, rand_byte());
    offer(OP_EOF, rand_byte());
    offer(OP_PUSH, rand_byte());
    offer(OP_PULL, rand_byte());

    settle();
    if (sb.mismatches == 0 && sb.pending_count() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- sim.f -----
src/rime_pkg.sv
src/rime_if.sv
src/rime_front.sv
src/rime_queue.sv
src/rime_back.sv
src/raw_image_mirror_engine.sv
src/rime_checker.sv
test/tb_top.sv
